// File: hdl/rfb_pkg.sv
package rfb_pkg;

  // Image geometry.
  localparam int MAX_DIM = 4096;
  localparam int DIM_W = $clog2(MAX_DIM) + 1;
  localparam int IDX_W = $clog2(MAX_DIM);

  // Fixed-point roots and the blend weight.
  localparam int ROOT_FRAC_BITS = 8;
  localparam int SUM_W = 2 * (IDX_W + 2);
  localparam int RAD_W = SUM_W + 2 * ROOT_FRAC_BITS;
  localparam int ROOT_W = RAD_W / 2;
  localparam int CORNER_W = ROOT_W - 1;
  localparam int BASE_W = IDX_W + ROOT_FRAC_BITS;
  localparam int WQ_W = 16;

  // Shared multiplier operands are signed.
  localparam int MUL_W = 18;

  // Configuration port.
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = DIM_W;

  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BORDER_RED   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BORDER_GREEN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BORDER_BLUE  = 3'd4;

  typedef struct packed {
    logic busy;
    logic done;
  } root_status_t;

endpackage

// File: hdl/rfb_isqrt.sv
module rfb_isqrt (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [rfb_pkg::RAD_W-1:0]    radicand,
  output logic [rfb_pkg::ROOT_W-1:0]   root,
  output rfb_pkg::root_status_t        status
);
  import rfb_pkg::*;

  localparam int CNT_W = $clog2(ROOT_W);

  logic [RAD_W-1:0]  rad;
  logic [ROOT_W+1:0] rem;
  logic [ROOT_W+1:0] rem_sh;
  logic [ROOT_W+1:0] trial;
  logic              fits;
  logic [CNT_W-1:0]  cnt;
  logic              busy;
  logic              done;

  // One result bit per cycle: bring down two radicand bits and try 4*root+1.
  always_comb begin
    rem_sh = {rem[ROOT_W-1:0], rad[RAD_W-1 -: 2]};
    trial  = {root, 2'b01};
    fits   = rem_sh >= trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(ROOT_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad  <= radicand;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      rad  <= rad << 2;
      rem  <= fits ? rem_sh - trial : rem_sh;
      root <= {root[ROOT_W-2:0], fits};
    end
  end

  assign status.busy = busy;
  assign status.done = done;

endmodule

// File: hdl/radial_frame_blend_unit.sv
// Radial vignette on a raster-order RGB pixel stream. The block counts rows and
// columns itself from image_width and image_height (saturated to 2..4096) and
// flags the last item of each row and frame. Pixels inside the circle of
// diameter min(width,height)-1 about the image center pass unchanged; pixels
// outside it are blended toward the border color by their fixed-point radial
// distance. One item is in work at a time, and pixel_stall is high meanwhile
// and during reset. A pixel inside the circle goes through the multiplier steps
// for the squared distance and the circle test and is then handed over. A pixel
// outside it goes on to the 22-step square-root recurrence, the 16-step
// restoring divider, blending the channels and handing over the result. A
// weight that saturates skips the divider. The first pixel of a frame first
// takes the root of the corner distance. A finished result sits in the output
// register, so the next item is taken while it waits; a result still held there
// stalls the following item at its end.
module radial_frame_blend_unit (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [rfb_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rfb_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                             pixel_valid,
  output logic                             pixel_stall,
  input  logic [7:0]                       red_in,
  input  logic [7:0]                       green_in,
  input  logic [7:0]                       blue_in,
  output logic                             result_valid,
  input  logic                             result_stall,
  output logic [7:0]                       red_out,
  output logic [7:0]                       green_out,
  output logic [7:0]                       blue_out,
  output logic                             row_end,
  output logic                             frame_end
);
  import rfb_pkg::*;

  localparam int DIV_CNT_W = $clog2(WQ_W);

  typedef enum logic [11:0] {
    S_IDLE   = 12'b000000000001,
    S_CW     = 12'b000000000010,
    S_CH     = 12'b000000000100,
    S_CROOT  = 12'b000000001000,
    S_SX     = 12'b000000010000,
    S_SY     = 12'b000000100000,
    S_SM     = 12'b000001000000,
    S_ROOT   = 12'b000010000000,
    S_DIVSET = 12'b000100000000,
    S_DIV    = 12'b001000000000,
    S_BLEND  = 12'b010000000000,
    S_DONE   = 12'b100000000000
  } state_t;

  state_t state;
  state_t state_next;

  // Configuration registers.
  logic [DIM_W-1:0] image_width;
  logic [DIM_W-1:0] image_height;
  logic [7:0]       border_red;
  logic [7:0]       border_green;
  logic [7:0]       border_blue;

  // Raster position and per-frame corner root.
  logic [IDX_W-1:0]    row_index;
  logic [IDX_W-1:0]    column_index;
  logic [CORNER_W-1:0] corner_root;

  // Working registers of the item in flight.
  logic [7:0]              pix [3];
  logic [7:0]              res [3];
  logic [IDX_W-1:0]        wm1;
  logic [IDX_W-1:0]        hm1;
  logic [IDX_W-1:0]        m;
  logic signed [IDX_W+2:0] dx;
  logic signed [IDX_W+2:0] dy;
  logic                    row_end_q;
  logic                    frame_end_q;
  logic [SUM_W-1:0]        acc;
  logic [WQ_W-1:0]         wq;
  logic [CORNER_W-1:0]     den;
  logic [CORNER_W-1:0]     drem;
  logic [DIV_CNT_W-1:0]    div_cnt;
  logic [1:0]              chan;
  logic                    root_start;

  // Accept-time decode.
  logic                    accept;
  logic                    need_corner;
  logic [DIM_W-1:0]        w_cl;
  logic [DIM_W-1:0]        h_cl;
  logic [DIM_W-1:0]        wm1_c;
  logic [DIM_W-1:0]        hm1_c;
  logic [DIM_W-1:0]        m_c;
  logic signed [IDX_W+2:0] dx_c;
  logic signed [IDX_W+2:0] dy_c;
  logic                    row_end_c;
  logic                    frame_end_c;

  // Shared multiplier.
  logic signed [MUL_W-1:0]   mul_a;
  logic signed [MUL_W-1:0]   mul_b;
  logic signed [2*MUL_W-1:0] mul_p;

  // Root unit.
  logic [RAD_W-1:0]  radicand;
  logic [ROOT_W-1:0] root;
  root_status_t      root_st;

  // Divider and blend datapath.
  logic [ROOT_W-1:0]   base;
  logic [ROOT_W-1:0]   num;
  logic [ROOT_W-1:0]   den_ext;
  logic [CORNER_W-1:0] den_c;
  logic [ROOT_W-1:0]   div_sh;
  logic [ROOT_W-1:0]   div_sub;
  logic                div_ge;
  logic [7:0]          bord_c;
  logic [8:0]          bdiff;
  logic signed [25:0]  bsum;
  logic                outside;

  assign accept      = pixel_valid && !pixel_stall;
  assign pixel_stall = rst || (state != S_IDLE);
  // The pixel at row 0, column 0 starts a frame and refreshes the corner root.
  assign need_corner = (row_index == '0) && (column_index == '0);

  always_comb begin
    if (image_width < DIM_W'(2)) w_cl = DIM_W'(2);
    else if (image_width > DIM_W'(MAX_DIM)) w_cl = DIM_W'(MAX_DIM);
    else w_cl = image_width;
    if (image_height < DIM_W'(2)) h_cl = DIM_W'(2);
    else if (image_height > DIM_W'(MAX_DIM)) h_cl = DIM_W'(MAX_DIM);
    else h_cl = image_height;
    wm1_c       = w_cl - 1'b1;
    hm1_c       = h_cl - 1'b1;
    m_c         = (w_cl < h_cl) ? wm1_c : hm1_c;
    dx_c        = (IDX_W+3)'({2'b00, column_index, 1'b1}) - (IDX_W+3)'({2'b00, w_cl});
    dy_c        = (IDX_W+3)'({2'b00, row_index, 1'b1}) - (IDX_W+3)'({2'b00, h_cl});
    row_end_c   = {1'b0, column_index} >= wm1_c;
    frame_end_c = row_end_c && ({1'b0, row_index} >= hm1_c);
  end

  always_comb begin
    bord_c = border_blue;
    case (chan)
      2'd0:    bord_c = border_red;
      2'd1:    bord_c = border_green;
      default: bord_c = border_blue;
    endcase
    bdiff = {1'b0, bord_c} - {1'b0, pix[chan]};
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_CW: begin
        mul_a = MUL_W'({1'b0, wm1});
        mul_b = MUL_W'({1'b0, wm1});
      end
      S_CH: begin
        mul_a = MUL_W'({1'b0, hm1});
        mul_b = MUL_W'({1'b0, hm1});
      end
      S_SX: begin
        mul_a = MUL_W'(dx);
        mul_b = MUL_W'(dx);
      end
      S_SY: begin
        mul_a = MUL_W'(dy);
        mul_b = MUL_W'(dy);
      end
      S_SM: begin
        mul_a = MUL_W'({1'b0, m});
        mul_b = MUL_W'({1'b0, m});
      end
      S_BLEND: begin
        mul_a = MUL_W'($signed(bdiff));
        mul_b = MUL_W'({1'b0, wq});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    mul_p = mul_a * mul_b;
  end

  assign outside  = acc > mul_p[SUM_W-1:0];
  assign radicand = {acc, {(2 * ROOT_FRAC_BITS){1'b0}}};

  rfb_isqrt u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (root_start),
    .radicand (radicand),
    .root     (root),
    .status   (root_st)
  );

  always_comb begin
    base    = ROOT_W'({m, {ROOT_FRAC_BITS{1'b0}}});
    num     = (root > base) ? root - base : '0;
    den_c   = (ROOT_W'(corner_root) > base) ? CORNER_W'(ROOT_W'(corner_root) - base) : '0;
    den_ext = {1'b0, den};
    div_sh  = {drem, 1'b0};
    div_ge  = div_sh >= den_ext;
    div_sub = div_sh - den_ext;
    // Blend as c + (b - c) * w, rounded half up; the result always fits 8 bits.
    bsum    = $signed({2'b00, pix[chan], 16'h0000}) + $signed(mul_p[25:0])
              + 26'sd32768;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (accept) state_next = need_corner ? S_CW : S_SX;
      S_CW:     state_next = S_CH;
      S_CH:     state_next = S_CROOT;
      S_CROOT:  if (root_st.done && !root_st.busy) state_next = S_SX;
      S_SX:     state_next = S_SY;
      S_SY:     state_next = S_SM;
      S_SM:     state_next = outside ? S_ROOT : S_DONE;
      S_ROOT:   if (root_st.done && !root_st.busy) state_next = S_DIVSET;
      S_DIVSET: state_next = ((den_c == '0) || (num >= ROOT_W'(den_c))) ? S_BLEND : S_DIV;
      S_DIV:    if (div_cnt == DIV_CNT_W'(WQ_W - 1)) state_next = S_BLEND;
      S_BLEND:  if (chan == 2'd2) state_next = S_DONE;
      S_DONE:   if (!result_valid || !result_stall) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      image_width  <= DIM_W'(640);
      image_height <= DIM_W'(480);
      border_red   <= '0;
      border_green <= '0;
      border_blue  <= '0;
      row_index    <= '0;
      column_index <= '0;
      corner_root  <= '0;
      result_valid <= 1'b0;
      root_start   <= 1'b0;
    end else begin
      state      <= state_next;
      root_start <= ((state == S_CH) || ((state == S_SM) && outside));
      if (cfg_write) begin
        unique case (cfg_index)
          CFG_IMAGE_WIDTH:  image_width  <= cfg_data;
          CFG_IMAGE_HEIGHT: image_height <= cfg_data;
          CFG_BORDER_RED:   border_red   <= cfg_data[7:0];
          CFG_BORDER_GREEN: border_green <= cfg_data[7:0];
          CFG_BORDER_BLUE:  border_blue  <= cfg_data[7:0];
          default: ;
        endcase
      end
      if (accept) begin
        if (frame_end_c) begin
          row_index    <= '0;
          column_index <= '0;
        end else if (row_end_c) begin
          row_index    <= row_index + 1'b1;
          column_index <= '0;
        end else begin
          column_index <= column_index + 1'b1;
        end
      end
      if ((state == S_CROOT) && root_st.done) begin
        corner_root <= root[CORNER_W-1:0];
      end
      if ((state == S_DONE) && (!result_valid || !result_stall)) begin
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          pix[0]      <= red_in;
          pix[1]      <= green_in;
          pix[2]      <= blue_in;
          wm1         <= wm1_c[IDX_W-1:0];
          hm1         <= hm1_c[IDX_W-1:0];
          m           <= m_c[IDX_W-1:0];
          dx          <= dx_c;
          dy          <= dy_c;
          row_end_q   <= row_end_c;
          frame_end_q <= frame_end_c;
        end
      end
      S_CW: acc <= mul_p[SUM_W-1:0];
      S_CH: acc <= acc + mul_p[SUM_W-1:0];
      S_SX: acc <= mul_p[SUM_W-1:0];
      S_SY: acc <= acc + mul_p[SUM_W-1:0];
      S_SM: begin
        res[0] <= pix[0];
        res[1] <= pix[1];
        res[2] <= pix[2];
      end
      S_DIVSET: begin
        den     <= den_c;
        drem    <= num[CORNER_W-1:0];
        div_cnt <= '0;
        wq      <= '1;
        chan    <= 2'd0;
      end
      S_DIV: begin
        drem    <= div_ge ? div_sub[CORNER_W-1:0] : div_sh[CORNER_W-1:0];
        wq      <= {wq[WQ_W-2:0], div_ge};
        div_cnt <= div_cnt + 1'b1;
      end
      S_BLEND: begin
        res[chan] <= bsum[23:16];
        chan      <= chan + 1'b1;
      end
      S_DONE: begin
        if (!result_valid || !result_stall) begin
          red_out   <= res[0];
          green_out <= res[1];
          blue_out  <= res[2];
          row_end   <= row_end_q;
          frame_end <= frame_end_q;
        end
      end
      default: ;
    endcase
  end

endmodule

// File: hdl/rfb_checker.sv
module rfb_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             pixel_valid,
  input logic                             pixel_stall,
  input logic                             result_valid,
  input logic                             result_stall,
  input logic [7:0]                       red_out,
  input logic [7:0]                       green_out,
  input logic [7:0]                       blue_out,
  input logic                             row_end,
  input logic                             frame_end
);

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid after reset");

  // The end of a frame is always also the end of a row.
  a_frame_row: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (!frame_end || row_end))
    else $error("frame end without row end");

  // One item at a time: the block is busy right after it takes one.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (pixel_valid && !pixel_stall) |=> pixel_stall)
    else $error("second item taken while one is in work");

  // A stalled result holds.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_stall) |=> (result_valid && $stable(red_out)
      && $stable(green_out) && $stable(blue_out) && $stable(row_end)
      && $stable(frame_end)))
    else $error("stalled result changed");

endmodule

bind radial_frame_blend_unit rfb_checker u_rfb_checker (
  .clk          (clk),
  .rst          (rst),
  .pixel_valid  (pixel_valid),
  .pixel_stall  (pixel_stall),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .red_out      (red_out),
  .green_out    (green_out),
  .blue_out     (blue_out),
  .row_end      (row_end),
  .frame_end    (frame_end)
);

// File: dv/radial_frame_blend_unit_tb.sv
module radial_frame_blend_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rfb_pkg::*;

  localparam int PIXEL_TARGET = 1900;
  localparam int NUM_REGS = 5;
  localparam int SETTLE_CYCLES = 8;
  localparam int TAIL_CYCLES = 100;
  localparam int QUIET_LIMIT = 4000;
  localparam int MAX_REPORTS = 100;

  typedef struct {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  typedef struct {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       row_last;
    logic       frame_last;
  } shaded_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  pixel_valid = 1'b0;
  logic                  pixel_stall;
  logic [7:0]            red_in = '0;
  logic [7:0]            green_in = '0;
  logic [7:0]            blue_in = '0;
  logic                  result_valid;
  logic                  result_stall = 1'b0;
  logic [7:0]            red_out;
  logic [7:0]            green_out;
  logic [7:0]            blue_out;
  logic                  row_end;
  logic                  frame_end;

  radial_frame_blend_unit dut (.*);

  always #2 clk = ~clk;

  // Shadow copy of the registers and the raster position.
  logic [CFG_DATA_W-1:0] width_reg = 13'd640;
  logic [CFG_DATA_W-1:0] height_reg = 13'd480;
  logic [7:0]            border_r = 8'd0;
  logic [7:0]            border_g = 8'd0;
  logic [7:0]            border_b = 8'd0;
  longint                row_pos = 0;
  longint                col_pos = 0;
  longint                corner_len = 0;

  rgb_t    raster_feed[$];
  shaded_t vignette_due[$];

  int errors = 0;
  int queued_px = 0;
  int accepted_px = 0;
  int blended_px = 0;
  int frame_ends = 0;
  int reg_writes = 0;
  int quiet_cycles = 0;
  int gap_left = 0;
  int burst_left = 0;
  int stall_mode = 0;
  int stall_span = 0;

  function automatic longint clamp_dim(logic [CFG_DATA_W-1:0] v);
    if (v < 2) return 2;
    if (v > MAX_DIM) return MAX_DIM;
    return longint'(v);
  endfunction

  function automatic longint root_floor(longint s);
    longint r;
    longint cand;
    int b;
    r = 0;
    for (b = 25; b >= 0; b--) begin
      cand = r | (longint'(1) << b);
      if (cand * cand <= s) r = cand;
    end
    return r;
  endfunction

  function automatic logic [7:0] mix_channel(longint c, longint b, longint wq);
    longint t;
    t = (c * (65536 - wq) + b * wq + 32768) >> 16;
    return t[7:0];
  endfunction

  // Works out the output item for one accepted pixel and advances the raster position.
  function automatic shaded_t shade_pixel(rgb_t px);
    shaded_t o;
    longint w, h, m, dx, dy, s, r, base, num, den, wq;
    w = clamp_dim(width_reg);
    h = clamp_dim(height_reg);
    m = (w < h ? w : h) - 1;
    if (row_pos == 0 && col_pos == 0)
      corner_len = root_floor(((w - 1) * (w - 1) + (h - 1) * (h - 1)) << (2 * ROOT_FRAC_BITS));
    dx = 2 * col_pos + 1 - w;
    dy = 2 * row_pos + 1 - h;
    s = dx * dx + dy * dy;
    o.red = px.red;
    o.green = px.green;
    o.blue = px.blue;
    if (s > m * m) begin
      r = root_floor(s << (2 * ROOT_FRAC_BITS));
      base = m << ROOT_FRAC_BITS;
      num = (r > base) ? r - base : 0;
      den = (corner_len > base) ? corner_len - base : 0;
      wq = 65535;
      if (den != 0 && num < den) wq = (num << 16) / den;
      if (wq > 65535) wq = 65535;
      o.red = mix_channel(longint'(px.red), longint'(border_r), wq);
      o.green = mix_channel(longint'(px.green), longint'(border_g), wq);
      o.blue = mix_channel(longint'(px.blue), longint'(border_b), wq);
      blended_px++;
    end
    o.row_last = col_pos >= w - 1;
    o.frame_last = o.row_last && row_pos >= h - 1;
    if (o.frame_last) begin
      row_pos = 0;
      col_pos = 0;
    end else if (o.row_last) begin
      row_pos++;
      col_pos = 0;
    end else begin
      col_pos++;
    end
    return o;
  endfunction

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      errors++;
      if (errors <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endfunction

  // Sender: bursts of random length separated by random gaps.
  always @(posedge clk) begin
    rgb_t px;
    if (rst) begin
      pixel_valid <= 1'b0;
    end else if (!(pixel_valid && pixel_stall)) begin
      if (gap_left > 0) begin
        gap_left--;
        pixel_valid <= 1'b0;
      end else if (raster_feed.size() > 0) begin
        px = raster_feed.pop_front();
        red_in <= px.red;
        green_in <= px.green;
        blue_in <= px.blue;
        pixel_valid <= 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 40);
          gap_left = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 8);
        end
      end else begin
        pixel_valid <= 1'b0;
      end
    end
  end

  // Receiver: stall pattern that switches between free, light, heavy and long holds.
  always @(posedge clk) begin
    if (stall_span == 0) begin
      stall_span = $urandom_range(10, 80);
      stall_mode = $urandom_range(0, 3);
    end else begin
      stall_span--;
    end
    case (stall_mode)
      0: result_stall <= 1'b0;
      1: result_stall <= ($urandom_range(0, 3) == 0);
      2: result_stall <= ($urandom_range(0, 3) != 0);
      default: result_stall <= stall_span[3];
    endcase
  end

  // Prediction on input accept, comparison on output accept, and the watchdog.
  always @(posedge clk) begin
    rgb_t    px;
    shaded_t want;
    if (!rst) begin
      if (pixel_valid && !pixel_stall) begin
        px.red = red_in;
        px.green = green_in;
        px.blue = blue_in;
        vignette_due.push_back(shade_pixel(px));
        accepted_px++;
      end
      if (result_valid && !result_stall) begin
        if (vignette_due.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("%0t: unexpected item, expected none, got r=%0d g=%0d b=%0d", $time,
                     red_out, green_out, blue_out);
        end else begin
          want = vignette_due.pop_front();
          check_field("red_out", want.red, red_out);
          check_field("green_out", want.green, green_out);
          check_field("blue_out", want.blue, blue_out);
          check_field("row_end", 8'(want.row_last), 8'(row_end));
          check_field("frame_end", 8'(want.frame_last), 8'(frame_end));
          if (want.frame_last) frame_ends++;
        end
      end
      if ((pixel_valid && !pixel_stall) || (result_valid && !result_stall) || cfg_write)
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no item moved for %0d cycles", $time, QUIET_LIMIT);
        $display("FAIL");
        $finish;
      end
    end
  end

  task automatic add_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    rgb_t px;
    px.red = r;
    px.green = g;
    px.blue = b;
    raster_feed.push_back(px);
    queued_px++;
  endtask

  task automatic add_random(int n);
    repeat (n) add_pixel(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                         8'($urandom_range(0, 255)));
  endtask

  // Waits until every queued pixel is taken and every result has come back.
  task automatic drain(int settle);
    do @(negedge clk);
    while (raster_feed.size() != 0 || pixel_valid || vignette_due.size() != 0);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    reg_writes++;
    case (idx)
      CFG_IMAGE_WIDTH:  width_reg = val;
      CFG_IMAGE_HEIGHT: height_reg = val;
      CFG_BORDER_RED:   border_r = val[7:0];
      CFG_BORDER_GREEN: border_g = val[7:0];
      CFG_BORDER_BLUE:  border_b = val[7:0];
      default: ;
    endcase
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_dim();
    int unsigned sel;
    sel = $urandom_range(0, 19);
    if (sel < 14) return CFG_DATA_W'($urandom_range(2, 24));
    if (sel < 16) return CFG_DATA_W'($urandom_range(0, 1));
    if (sel < 18) return CFG_DATA_W'($urandom_range(25, 300));
    return CFG_DATA_W'($urandom_range(301, 2 ** CFG_DATA_W - 1));
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_color();
    int unsigned sel;
    sel = $urandom_range(0, 7);
    if (sel == 0) return '0;
    if (sel == 1) return CFG_DATA_W'(255);
    return CFG_DATA_W'($urandom_range(0, 255));
  endfunction

  function automatic int pixels_to_frame_end(longint w, longint h);
    longint r, c;
    int n;
    bit done;
    r = row_pos;
    c = col_pos;
    n = 0;
    done = 0;
    while (!done) begin
      n++;
      if (c >= w - 1) begin
        if (r >= h - 1) done = 1;
        else begin
          r++;
          c = 0;
        end
      end else begin
        c++;
      end
    end
    return n;
  endfunction

  initial begin
    longint w, h;
    int n;
    int i;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Reset geometry: the first pixel sits at row 0, column 0 of a 640x480 frame.
    add_pixel(8'd255, 8'd255, 8'd255);
    add_pixel(8'd0, 8'd0, 8'd0);
    add_pixel(8'd128, 8'd64, 8'd200);
    drain(SETTLE_CYCLES);

    // Shrinking the width mid row ends the row at once; then finish a 4x3 frame.
    write_reg(CFG_IMAGE_WIDTH, 13'd4);
    write_reg(CFG_IMAGE_HEIGHT, 13'd3);
    write_reg(CFG_BORDER_RED, 13'd255);
    write_reg(CFG_BORDER_GREEN, 13'd0);
    write_reg(CFG_BORDER_BLUE, 13'd170);
    add_pixel(8'd255, 8'd0, 8'd255);
    add_pixel(8'd0, 8'd255, 8'd0);
    add_random(7);
    drain(SETTLE_CYCLES);

    // Dimensions below the minimum saturate to 2; writes past the last register do nothing.
    write_reg(CFG_IMAGE_WIDTH, 13'd1);
    write_reg(CFG_IMAGE_HEIGHT, 13'd0);
    write_reg(CFG_BORDER_RED, 13'd0);
    write_reg(CFG_BORDER_GREEN, 13'd255);
    write_reg(CFG_BORDER_BLUE, 13'd85);
    for (i = NUM_REGS; i < 2 ** CFG_IDX_W; i++)
      write_reg(CFG_IDX_W'(i), (i % 2 == 0) ? '1 : '0);
    add_pixel(8'd255, 8'd255, 8'd255);
    add_pixel(8'd0, 8'd0, 8'd0);
    add_pixel(8'd255, 8'd0, 8'd255);
    add_pixel(8'd0, 8'd255, 8'd0);
    add_pixel(8'd170, 8'd85, 8'd1);
    drain(SETTLE_CYCLES);

    // Growing past the stored corner distance leaves a zero weight denominator.
    write_reg(CFG_IMAGE_WIDTH, 13'h1fff);
    write_reg(CFG_IMAGE_HEIGHT, 13'd4097);
    add_random(2);
    drain(SETTLE_CYCLES);
    write_reg(CFG_IMAGE_WIDTH, 13'd3);
    add_random(1);
    drain(SETTLE_CYCLES);
    write_reg(CFG_IMAGE_HEIGHT, 13'd2);
    add_random(3);
    drain(SETTLE_CYCLES);

    // Largest frame, starting at its corner.
    write_reg(CFG_IMAGE_WIDTH, 13'd4096);
    write_reg(CFG_IMAGE_HEIGHT, 13'd4096);
    add_random(2);

    while (queued_px < PIXEL_TARGET) begin
      drain(SETTLE_CYCLES);
      if ($urandom_range(0, 3) != 0) write_reg(CFG_IMAGE_WIDTH, pick_dim());
      if ($urandom_range(0, 3) != 0) write_reg(CFG_IMAGE_HEIGHT, pick_dim());
      if ($urandom_range(0, 2) == 0) write_reg(CFG_BORDER_RED, pick_color());
      if ($urandom_range(0, 2) == 0) write_reg(CFG_BORDER_GREEN, pick_color());
      if ($urandom_range(0, 2) == 0) write_reg(CFG_BORDER_BLUE, pick_color());
      if ($urandom_range(0, 9) == 0)
        write_reg(CFG_IDX_W'($urandom_range(NUM_REGS, 2 ** CFG_IDX_W - 1)),
                  CFG_DATA_W'($urandom_range(0, 2 ** CFG_DATA_W - 1)));
      w = clamp_dim(width_reg);
      h = clamp_dim(height_reg);
      // Small frames are mostly run to their end, sometimes with a whole frame more.
      if (w * h <= 400 && $urandom_range(0, 3) != 0)
        n = int'(pixels_to_frame_end(w, h) + $urandom_range(0, 1) * w * h);
      else
        n = $urandom_range(5, 80);
      if (n > PIXEL_TARGET - queued_px) n = PIXEL_TARGET - queued_px;
      add_random(n);
    end

    drain(TAIL_CYCLES);
    $display("Run covered %0d pixels, %0d blended toward the border, %0d frame ends,",
             accepted_px, blended_px, frame_ends);
    $display("across %0d register writes, with %0d mismatches.", reg_writes, errors);
    if (errors == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

// File: sim.f
hdl/rfb_pkg.sv
hdl/rfb_isqrt.sv
hdl/radial_frame_blend_unit.sv
hdl/rfb_checker.sv
dv/radial_frame_blend_unit_tb.sv
